FILE: design/vvfe_pkg.sv
// ----------------------------------------------------------------------------
// vvfe_pkg
// Shared constants, codes and controller/datapath interface types for the
// voxel visible-face extractor.
// ----------------------------------------------------------------------------
package vvfe_pkg;

	// Chunk geometry
	localparam int CHUNK_SIZE = 16;
	localparam int ID_BITS    = 8;
	localparam int NCELLS     = CHUNK_SIZE * CHUNK_SIZE * CHUNK_SIZE;
	localparam int ADDR_W     = $clog2(NCELLS);
	localparam int CRD_W      = (CHUNK_SIZE > 2) ? $clog2(CHUNK_SIZE) : 1;
	localparam int Q1_W       = $clog2(CHUNK_SIZE * CHUNK_SIZE);

	// Face counter saturation point
	localparam int FACE_LIMIT_RAW = 6 * NCELLS - 1;
	localparam int FACE_LIMIT     = (FACE_LIMIT_RAW > 32767) ? 32767 : FACE_LIMIT_RAW;

	// Reciprocals for index decomposition (exact for indexes below 2^16)
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 29;
	localparam int RECIP_N     = ((1 << RECIP_SHIFT) + CHUNK_SIZE - 1) / CHUNK_SIZE;
	localparam int RECIP_NN    = ((1 << RECIP_SHIFT) + CHUNK_SIZE * CHUNK_SIZE - 1)
		/ (CHUNK_SIZE * CHUNK_SIZE);

	// Operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_EMIT  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Read selects: the six face directions, then the cell itself
	typedef enum logic [2:0] {
		RD_NX     = 3'd0,
		RD_NY     = 3'd1,
		RD_PX     = 3'd2,
		RD_PY     = 3'd3,
		RD_PZ     = 3'd4,
		RD_NZ     = 3'd5,
		RD_CENTER = 3'd6
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic    cap;
		logic    wr_en;
		logic    cnt_clr;
		logic    clr_step;
		logic    div1;
		logic    div2;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    emit_load;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_range;
		logic clr_done;
		logic out_free;
		logic face_pending;
		logic last_pending;
	} ctl_sts_t;

endpackage

FILE: design/vvfe_ctrl.sv
// ----------------------------------------------------------------------------
// vvfe_ctrl
// Sequencer: clearing pass after reset, operation decode, index split,
// seven cell reads per emit and one face per cycle out while the output is free.
// ----------------------------------------------------------------------------
module vvfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          op,
	input  vvfe_pkg::ctl_sts_t  sts,
	output logic                in_ready,
	output vvfe_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_READ,
		S_WAIT,
		S_EMIT
	} state_t;

	localparam logic [2:0] LAST_RD = 3'(vvfe_pkg::RD_CENTER);

	state_t     state_q;
	logic [2:0] rd_cnt_q;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Command decode
	always_comb begin
		cmd = '0;
		cmd.rd_sel = vvfe_pkg::rd_sel_t'(rd_cnt_q);
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					unique case (vvfe_pkg::op_t'(op))
						vvfe_pkg::OP_WRITE: cmd.wr_en = sts.in_range;
						vvfe_pkg::OP_CLEAR: cmd.cnt_clr = 1'b1;
						default: ;
					endcase
				end
			end
			S_DIV1: cmd.div1 = 1'b1;
			S_DIV2: cmd.div2 = 1'b1;
			S_READ: cmd.rd_en = 1'b1;
			S_WAIT: ;
			S_EMIT: cmd.emit_load = sts.face_pending && sts.out_free;
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			rd_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_done)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept && vvfe_pkg::op_t'(op) == vvfe_pkg::OP_EMIT && sts.in_range)
						state_q <= S_DIV1;
				end
				S_DIV1: state_q <= S_DIV2;
				S_DIV2: begin
					rd_cnt_q <= '0;
					state_q  <= S_READ;
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == LAST_RD)
						state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_EMIT;
				S_EMIT: begin
					if (!sts.face_pending)
						state_q <= S_IDLE;
					else if (sts.out_free && sts.last_pending)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/vvfe_datapath.sv
// ----------------------------------------------------------------------------
// vvfe_datapath
// Block store memory, index split into x/y/z, neighbor addressing,
// exposure mask, face counter and the result register.
// ----------------------------------------------------------------------------
module vvfe_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  vvfe_pkg::ctl_cmd_t  cmd,
	output vvfe_pkg::ctl_sts_t  sts,
	input  logic [11:0]         cell_index,
	input  logic [7:0]          cell_value,
	input  logic [9:0]          chunk_x,
	input  logic [9:0]          chunk_y,
	input  logic [9:0]          chunk_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          face_dir,
	output logic [7:0]          block_id,
	output logic [13:0]         world_x,
	output logic [13:0]         world_y,
	output logic [13:0]         world_z,
	output logic [14:0]         face_number,
	output logic                last_face
);

	localparam int AW = vvfe_pkg::ADDR_W;
	localparam int CW = vvfe_pkg::CRD_W;
	localparam int IW = vvfe_pkg::ID_BITS;
	localparam int PW = 16 + vvfe_pkg::RECIP_W;
	localparam int Q1_BITS = vvfe_pkg::Q1_W;
	localparam logic [CW-1:0] CRD_MAX = CW'(vvfe_pkg::CHUNK_SIZE - 1);

	// Block store
	logic [IW-1:0] mem [vvfe_pkg::NCELLS];
	logic [IW-1:0] rdata_s1;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [IW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;

	// Captured item
	logic [AW-1:0]   idx_q;
	logic [9:0]      chunk_x_q, chunk_y_q, chunk_z_q;
	logic [Q1_BITS-1:0] q1_q;
	logic [CW-1:0]   x_q, y_q, z_q;

	// Read capture, cell id, exposure mask, counters
	logic                 rd_valid_s1;
	vvfe_pkg::rd_sel_t    rd_sel_s1;
	logic [IW-1:0]        id_q;
	logic [5:0]           mask_q;
	logic [AW-1:0]        clr_addr_q;
	logic [14:0]          count_q;
	logic                 out_valid_q;
	logic [2:0]           face_dir_q;
	logic [7:0]           block_id_q;
	logic [13:0]          world_x_q, world_y_q, world_z_q;
	logic [14:0]          face_number_q;
	logic                 last_q;

	logic [15:0] idx16, base16, nb16, val16, id16, q1_16;
	logic [PW-1:0] prod_n, prod_nn;
	logic [15:0] x16, y16;
	logic [5:0]  border;
	logic [5:0]  pick_oh;
	logic [2:0]  pick_dir;
	logic [5:0]  mask_rest;

	// Input range check and write data
	assign idx16        = 16'(cell_index);
	assign val16        = 16'(cell_value);
	assign sts.in_range = idx16 < 16'(vvfe_pkg::NCELLS);
	assign sts.clr_done = clr_addr_q == AW'(vvfe_pkg::NCELLS - 1);

	// Index split by reciprocal multiplication
	assign base16  = 16'(idx_q);
	assign prod_n  = PW'(base16) * PW'(vvfe_pkg::RECIP_N);
	assign prod_nn = PW'(base16) * PW'(vvfe_pkg::RECIP_NN);
	assign q1_16   = 16'(q1_q);
	assign x16     = base16 - 16'(q1_16 * 16'(vvfe_pkg::CHUNK_SIZE));
	assign y16     = q1_16 - 16'(16'(z_q) * 16'(vvfe_pkg::CHUNK_SIZE));

	// Border flags in face order
	assign border[0] = x_q == '0;
	assign border[1] = y_q == '0;
	assign border[2] = x_q == CRD_MAX;
	assign border[3] = y_q == CRD_MAX;
	assign border[4] = z_q == CRD_MAX;
	assign border[5] = z_q == '0;

	// Neighbor address; a cell on the border reads itself (result is masked)
	always_comb begin
		nb16 = base16;
		unique case (cmd.rd_sel)
			vvfe_pkg::RD_NX: if (!border[0]) nb16 = base16 - 16'd1;
			vvfe_pkg::RD_NY: if (!border[1]) nb16 = base16 - 16'(vvfe_pkg::CHUNK_SIZE);
			vvfe_pkg::RD_PX: if (!border[2]) nb16 = base16 + 16'd1;
			vvfe_pkg::RD_PY: if (!border[3]) nb16 = base16 + 16'(vvfe_pkg::CHUNK_SIZE);
			vvfe_pkg::RD_PZ: if (!border[4])
				nb16 = base16 + 16'(vvfe_pkg::CHUNK_SIZE * vvfe_pkg::CHUNK_SIZE);
			vvfe_pkg::RD_NZ: if (!border[5])
				nb16 = base16 - 16'(vvfe_pkg::CHUNK_SIZE * vvfe_pkg::CHUNK_SIZE);
			default: nb16 = base16;
		endcase
	end

	// Memory port selection
	assign mem_we    = cmd.clr_step || cmd.wr_en;
	assign mem_waddr = cmd.clr_step ? clr_addr_q : idx16[AW-1:0];
	assign mem_wdata = cmd.clr_step ? '0 : val16[IW-1:0];
	assign mem_raddr = nb16[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_s1 <= mem[mem_raddr];
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr_step)
			clr_addr_q <= clr_addr_q + AW'(1);
	end

	// Item capture and index split
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			idx_q     <= idx16[AW-1:0];
			chunk_x_q <= chunk_x;
			chunk_y_q <= chunk_y;
			chunk_z_q <= chunk_z;
		end
		if (cmd.div1) begin
			q1_q <= prod_n[vvfe_pkg::RECIP_SHIFT +: Q1_BITS];
			z_q  <= prod_nn[vvfe_pkg::RECIP_SHIFT +: CW];
		end
		if (cmd.div2) begin
			x_q <= x16[CW-1:0];
			y_q <= y16[CW-1:0];
		end
	end

	// Read capture into cell id and exposure mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_sel_s1   <= vvfe_pkg::RD_CENTER;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			rd_sel_s1   <= cmd.rd_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (rd_sel_s1 == vvfe_pkg::RD_CENTER)
				id_q <= rdata_s1;
			else
				mask_q[3'(rd_sel_s1)] <= border[3'(rd_sel_s1)] || (rdata_s1 == '0);
		end else if (cmd.emit_load) begin
			mask_q <= mask_rest;
		end
	end

	// Lowest pending face
	always_comb begin
		pick_oh  = '0;
		pick_dir = '0;
		for (int i = 5; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick_oh  = 6'(1) << i;
				pick_dir = 3'(i);
			end
		end
	end

	assign mask_rest        = mask_q & ~pick_oh;
	assign sts.face_pending = (id_q != '0) && (mask_q != '0);
	assign sts.last_pending = mask_rest == '0;
	assign sts.out_free     = !out_valid_q || out_ready;

	// Face counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr)
				count_q <= '0;
			else if (cmd.emit_load && count_q < 15'(vvfe_pkg::FACE_LIMIT))
				count_q <= count_q + 15'd1;
			if (cmd.emit_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result payload
	assign id16 = 16'(id_q);

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			face_dir_q    <= pick_dir;
			block_id_q    <= id16[7:0];
			world_x_q     <= 14'(14'(chunk_x_q) * 14'(vvfe_pkg::CHUNK_SIZE)) + 14'(x_q);
			world_y_q     <= 14'(14'(chunk_y_q) * 14'(vvfe_pkg::CHUNK_SIZE)) + 14'(y_q);
			world_z_q     <= 14'(14'(chunk_z_q) * 14'(vvfe_pkg::CHUNK_SIZE)) + 14'(z_q);
			face_number_q <= count_q;
			last_q        <= mask_rest == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign face_dir    = face_dir_q;
	assign block_id    = block_id_q;
	assign world_x     = world_x_q;
	assign world_y     = world_y_q;
	assign world_z     = world_z_q;
	assign face_number = face_number_q;
	assign last_face   = last_q;

endmodule

FILE: design/voxel_visible_face_extract_top.sv
// ----------------------------------------------------------------------------
// voxel_visible_face_extract_top
// Visible-face extractor for one cubic chunk of block ids.
//
// Input channel (in_valid/in_ready): op selects write cell, emit faces of a
// cell, or clear the face count. Output channel (out_valid/out_ready): one
// item per exposed face of an emitted cell, in order -x, -y, +x, +y, +z, -z,
// with last_face marking the final face of the cell.
// Sequence: a write or a clear is carried out as it is accepted. An emit
// passes through capture, the index-split states DIV1 and DIV2, seven
// reads of the block store, a capture state for the last read, then the
// output of each exposed face in turn, if any; the reads go one at a time
// through the store's one read port. A new item is taken once the last face
// of the previous one sits in the output register.
// Reset: the block store is swept to zero one cell per cycle, all
// CHUNK_SIZE^3 cells, with in_ready low; the face count starts at zero.
// Stall: while out_ready is low the face in the output register holds and
// the remaining faces of the cell wait.
// ----------------------------------------------------------------------------
module voxel_visible_face_extract_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] cell_index,
	input  logic [7:0]  cell_value,
	input  logic [9:0]  chunk_x,
	input  logic [9:0]  chunk_y,
	input  logic [9:0]  chunk_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  face_dir,
	output logic [7:0]  block_id,
	output logic [13:0] world_x,
	output logic [13:0] world_y,
	output logic [13:0] world_z,
	output logic [14:0] face_number,
	output logic        last_face
);

	vvfe_pkg::ctl_cmd_t cmd;
	vvfe_pkg::ctl_sts_t sts;

	// Sequencer
	vvfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Store, address and result logic
	vvfe_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cell_index  (cell_index),
		.cell_value  (cell_value),
		.chunk_x     (chunk_x),
		.chunk_y     (chunk_y),
		.chunk_z     (chunk_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.face_dir    (face_dir),
		.block_id    (block_id),
		.world_x     (world_x),
		.world_y     (world_y),
		.world_z     (world_z),
		.face_number (face_number),
		.last_face   (last_face)
	);

	// Faces only come from non-empty cells
	a_block_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_id != 8'd0)
		else $error("face emitted for an empty cell");

	// No new item while faces of the current cell remain
	a_no_accept_mid_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_face |-> !in_ready)
		else $error("input accepted before last face of cell");

	// Face number never passes the saturation point
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face_number <= 15'(vvfe_pkg::FACE_LIMIT))
		else $error("face number beyond saturation limit");

endmodule
